/* rtl/core/quad_x_motor_mixer_assert.svh */
// Assertion macros for the quad X motor mixer.
// Expects signals named clk and rst_n in the scope of use.
`ifndef QUAD_X_MOTOR_MIXER_ASSERT_SVH
`define QUAD_X_MOTOR_MIXER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define QXM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define QXM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/qxm_pkg.sv */
// Shared types, constants and arithmetic helpers of the quad X motor mixer.
// No dependencies.
package qxm_pkg;

    localparam int CmdW     = 16;
    localparam int PulseW   = 12;
    localparam int MixW     = 18;       // sum of four Q2.14 words
    localparam int DivW     = 17;       // divisor and partial remainder
    localparam int ScaleW   = 14;       // reciprocal quotient bits
    localparam int DivSteps = ScaleW;   // one quotient bit per stage
    localparam int CfgIdxW  = 4;
    localparam int QDepth   = 2;
    localparam int QPtrW    = 1;
    localparam int QCntW    = 2;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_MIN_PULSE = 4'd0;
    localparam logic [CfgIdxW-1:0] REG_MAX_PULSE = 4'd1;

    localparam logic [PulseW-1:0] MIN_PULSE_RST = 12'd1000;
    localparam logic [PulseW-1:0] MAX_PULSE_RST = 12'd2000;

    // 1.0 in Q2.14, and the unit scale used when no desaturation is needed
    localparam logic signed [MixW-1:0] ONE_Q14   = 18'sd16384;
    localparam logic [ScaleW:0]        SCALE_ONE = 15'd16384;
    // Top bits of 2^28 that start the long division (below any divisor used)
    localparam logic [DivW-1:0]        DIV_SEED  = 17'd16384;

    typedef logic signed [CmdW-1:0] cmd_word_t;
    typedef logic signed [MixW-1:0] mix_t;
    typedef logic [PulseW-1:0]      pulse_t;

    // One classified item: four mixes, largest mix as divisor, desat flag
    typedef struct packed {
        mix_t             fr;
        mix_t             fl;
        mix_t             bl;
        mix_t             br;
        logic [DivW-1:0]  den;
        logic             sat;
    } mix_word_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic [QCntW-1:0] count;
        logic             full;
    } qstat_t;

    // floor(mix * scale / 2^14)
    function automatic mix_t scale_mix(mix_t mix, logic [ScaleW:0] scale);
        logic signed [MixW+ScaleW+1:0] prod;
        prod = (MixW+ScaleW+2)'(mix) * (MixW+ScaleW+2)'($signed({1'b0, scale}));
        return prod[MixW+ScaleW-1:ScaleW];
    endfunction

    // min + floor(clamp(mix) * span / 2^14), wrapped to pulse width
    function automatic pulse_t pulse_of(mix_t mix, pulse_t min_pulse, pulse_t span);
        logic [ScaleW:0]        m;
        logic [ScaleW+PulseW:0] prod;
        m    = mix[MixW-1] ? '0 : mix[ScaleW:0];
        prod = {{PulseW{1'b0}}, m} * {{(ScaleW+1){1'b0}}, span};
        return min_pulse + prod[ScaleW+PulseW-1:ScaleW];
    endfunction

endpackage

/* rtl/core/qxm_if.sv */
// Channel interfaces of the quad X motor mixer: commands, pulses, config writes.
// Depends on qxm_pkg.
interface qxm_cmd_if;
    import qxm_pkg::*;
    logic      valid;
    logic      ready;
    cmd_word_t throttle;
    cmd_word_t pitch;
    cmd_word_t roll;
    cmd_word_t yaw;

    modport source (output valid, output throttle, output pitch, output roll,
                    output yaw, input ready);
    modport sink   (input valid, input throttle, input pitch, input roll,
                    input yaw, output ready);
endinterface

interface qxm_pulse_if;
    import qxm_pkg::*;
    logic   valid;
    logic   ready;
    pulse_t front_right_pulse;
    pulse_t front_left_pulse;
    pulse_t back_left_pulse;
    pulse_t back_right_pulse;

    modport source (output valid, output front_right_pulse, output front_left_pulse,
                    output back_left_pulse, output back_right_pulse, input ready);
    modport sink   (input valid, input front_right_pulse, input front_left_pulse,
                    input back_left_pulse, input back_right_pulse, output ready);
endinterface

interface qxm_cfg_if;
    import qxm_pkg::*;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    pulse_t             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/qxm_front.sv */
// Front end: forms the four X-frame mixes, finds the largest, flags desaturation.
// Depends on qxm_pkg and qxm_if.
module qxm_front (
    qxm_cmd_if.sink            cmd,
    input  logic               push_ready,
    output logic               push_valid,
    output qxm_pkg::mix_word_t push_word
);
    import qxm_pkg::*;

    mix_t t, p, r, y;
    mix_t fr, fl, bl, br;
    mix_t max_a, max_b, max_all;

    // Sign extend commands to mix width
    assign t = {{(MixW-CmdW){cmd.throttle[CmdW-1]}}, cmd.throttle};
    assign p = {{(MixW-CmdW){cmd.pitch[CmdW-1]}},    cmd.pitch};
    assign r = {{(MixW-CmdW){cmd.roll[CmdW-1]}},     cmd.roll};
    assign y = {{(MixW-CmdW){cmd.yaw[CmdW-1]}},      cmd.yaw};

    // X-frame mixes
    assign fr = t + p - r - y;
    assign fl = t + p + r + y;
    assign bl = t - p + r - y;
    assign br = t - p - r + y;

    // Largest mix, two-level compare
    assign max_a   = (fr > fl) ? fr : fl;
    assign max_b   = (bl > br) ? bl : br;
    assign max_all = (max_a > max_b) ? max_a : max_b;

    always_comb
    begin
        push_word.fr  = fr;
        push_word.fl  = fl;
        push_word.bl  = bl;
        push_word.br  = br;
        push_word.den = max_all[DivW-1:0];
        push_word.sat = max_all > ONE_Q14;
    end

    assign push_valid = cmd.valid;
    assign cmd.ready  = push_ready;

endmodule

/* rtl/core/qxm_queue.sv */
// Two-entry queue between front and back; either side may stall on its own.
// Depends on qxm_pkg.
module qxm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  qxm_pkg::mix_word_t push_word,
    output logic               push_ready,
    output logic               head_valid,
    output qxm_pkg::mix_word_t head_word,
    input  logic               head_take,
    output qxm_pkg::qstat_t    stat
);
    import qxm_pkg::*;

    mix_word_t        entry_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign push_ready = cnt_reg != QCntW'(QDepth);
    assign head_valid = cnt_reg != '0;
    assign head_word  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = head_take && head_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCntW'(push) - QCntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign stat.count = cnt_reg;
    assign stat.full  = !push_ready;

endmodule

/* rtl/core/qxm_back.sv */
// Back end: pipelined reciprocal 2^28/max, desaturation scale, pulse mapping.
// Depends on qxm_pkg and qxm_if.
module qxm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  qxm_pkg::mix_word_t head_word,
    output logic               head_take,
    input  qxm_pkg::pulse_t    min_pulse,
    input  qxm_pkg::pulse_t    max_pulse,
    qxm_pulse_if.source        pulses
);
    import qxm_pkg::*;

    // Divider stage registers
    logic             st_valid_reg [DivSteps];
    mix_word_t        st_word_reg  [DivSteps];
    logic [DivW-1:0]  st_rem_reg   [DivSteps];
    logic [ScaleW-1:0] st_quo_reg  [DivSteps];

    // Divider stage inputs and next values
    logic             stg_in_valid [DivSteps];
    mix_word_t        stg_in_word  [DivSteps];
    logic [DivW-1:0]  stg_in_rem   [DivSteps];
    logic [ScaleW-1:0] stg_in_quo  [DivSteps];
    logic [DivW-1:0]  st_rem_next  [DivSteps];
    logic [ScaleW-1:0] st_quo_next [DivSteps];

    // Scale stage and output stage
    logic      mul_valid_reg;
    mix_t      mul_fr_reg, mul_fl_reg, mul_bl_reg, mul_br_reg;
    mix_word_t div_last;
    logic [ScaleW:0] scale;

    logic      out_valid_reg;
    pulse_t    out_fr_reg, out_fl_reg, out_bl_reg, out_br_reg;
    pulse_t    span;

    logic      adv;

    // Whole pipe moves unless a finished word is stuck at the output
    assign adv       = !out_valid_reg || pulses.ready;
    assign head_take = adv;

    // Stage inputs: first stage from the queue head, others from the previous stage
    always_comb
    begin
        stg_in_valid[0] = head_valid;
        stg_in_word[0]  = head_word;
        stg_in_rem[0]   = DIV_SEED;
        stg_in_quo[0]   = '0;
        for (int k = 1; k < DivSteps; k++)
        begin
            stg_in_valid[k] = st_valid_reg[k-1];
            stg_in_word[k]  = st_word_reg[k-1];
            stg_in_rem[k]   = st_rem_reg[k-1];
            stg_in_quo[k]   = st_quo_reg[k-1];
        end
    end

    // Restoring division, one quotient bit per stage
    always_comb
    begin
        logic [DivW:0] rem2;
        logic          fits;
        for (int k = 0; k < DivSteps; k++)
        begin
            rem2 = {stg_in_rem[k], 1'b0};
            fits = rem2 >= {1'b0, stg_in_word[k].den};
            st_rem_next[k] = fits ? DivW'(rem2 - {1'b0, stg_in_word[k].den})
                                  : DivW'(rem2);
            st_quo_next[k] = {stg_in_quo[k][ScaleW-2:0], fits};
        end
    end

    // Desaturation scale: reciprocal when saturated, else unity
    assign div_last = st_word_reg[DivSteps-1];
    assign scale    = div_last.sat ? {1'b0, st_quo_reg[DivSteps-1]} : SCALE_ONE;

    // Inverted span reads as zero
    assign span = (max_pulse >= min_pulse) ? max_pulse - min_pulse : '0;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DivSteps; k++)
            begin
                st_valid_reg[k] <= 1'b0;
            end
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            for (int k = 0; k < DivSteps; k++)
            begin
                st_valid_reg[k] <= stg_in_valid[k];
            end
            mul_valid_reg <= st_valid_reg[DivSteps-1];
            out_valid_reg <= mul_valid_reg;
        end
    end

    // Payload pipe
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DivSteps; k++)
            begin
                st_word_reg[k] <= stg_in_word[k];
                st_rem_reg[k]  <= st_rem_next[k];
                st_quo_reg[k]  <= st_quo_next[k];
            end
            mul_fr_reg <= scale_mix(div_last.fr, scale);
            mul_fl_reg <= scale_mix(div_last.fl, scale);
            mul_bl_reg <= scale_mix(div_last.bl, scale);
            mul_br_reg <= scale_mix(div_last.br, scale);
            out_fr_reg <= pulse_of(mul_fr_reg, min_pulse, span);
            out_fl_reg <= pulse_of(mul_fl_reg, min_pulse, span);
            out_bl_reg <= pulse_of(mul_bl_reg, min_pulse, span);
            out_br_reg <= pulse_of(mul_br_reg, min_pulse, span);
        end
    end

    assign pulses.valid             = out_valid_reg;
    assign pulses.front_right_pulse = out_fr_reg;
    assign pulses.front_left_pulse  = out_fl_reg;
    assign pulses.back_left_pulse   = out_bl_reg;
    assign pulses.back_right_pulse  = out_br_reg;

endmodule

/* rtl/core/quad_x_motor_mixer.sv */
// Quad X motor mixer: takes one throttle/pitch/roll/yaw word per clock and
// returns four motor pulse widths per word, in order. Sustained rate is one word
// per cycle while the output is not held; a result passes through the queue,
// the 14-stage pipelined reciprocal (2^28/max), one scale stage and the output
// register. A two-entry queue sits between the mixing front end and
// the pipelined back end; when the output is held, the back end freezes and the
// queue absorbs up to two words before cmd.ready drops. Config writes are taken
// every cycle and must only be issued while no word is in flight.
// Depends on qxm_pkg, qxm_if, qxm_front, qxm_queue, qxm_back.
`include "quad_x_motor_mixer_assert.svh"

module quad_x_motor_mixer (
    input  logic        clk,
    input  logic        rst_n,
    qxm_cfg_if.sink     cfg,
    qxm_cmd_if.sink     cmd,
    qxm_pulse_if.source pulses
);
    import qxm_pkg::*;

    pulse_t    min_pulse_reg;
    pulse_t    max_pulse_reg;

    logic      push_valid, push_ready;
    mix_word_t push_word;
    logic      head_valid, head_take;
    mix_word_t head_word;
    qstat_t    q_stat;

    // Config registers; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_MIN_PULSE: min_pulse_reg <= cfg.data;
                REG_MAX_PULSE: max_pulse_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    qxm_front u_front (
        .cmd        (cmd),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_word  (push_word)
    );

    qxm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_word  (push_word),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_word  (head_word),
        .head_take  (head_take),
        .stat       (q_stat)
    );

    qxm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_word  (head_word),
        .head_take  (head_take),
        .min_pulse  (min_pulse_reg),
        .max_pulse  (max_pulse_reg),
        .pulses     (pulses)
    );

    // A full queue must hold off new commands
    `QXM_ASSERT_IMPLY(a_full_blocks_cmd, q_stat.full, !cmd.ready, "command taken into full queue")
    // While the output is held, nothing may drain from the queue
    `QXM_ASSERT_NEXT(a_stall_keeps_queue, pulses.valid && !pulses.ready, q_stat.count >= $past(q_stat.count), "queue drained during output stall")
    // An accepted command always lands in the queue
    `QXM_ASSERT_NEXT(a_cmd_lands, cmd.valid && cmd.ready, q_stat.count != '0, "accepted command lost before queue")

endmodule
